// ===== src/utg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utg_pkg
// Shared types, constants and calendar tables for the UTC to GNSS time unit.
// ----------------------------------------------------------------------------
package utg_pkg;

  localparam logic [16:0] SEC_PER_DAY    = 17'd86400;
  localparam logic [16:0] UTC3_SHIFT     = 17'd10800;
  localparam logic [11:0] BASE_YEAR      = 12'd2000;
  localparam logic [11:0] LAST_YEAR      = 12'd2099;
  // days from each epoch to 2000-01-01
  localparam logic [15:0] GPS_EPOCH_DAYS = 16'd7300;
  localparam logic [15:0] GAL_EPOCH_DAYS = 16'd132;
  // floor(x / 7) = (x * DIV7_RECIP) >> DIV7_SHIFT, exact for x < 104857
  localparam logic [31:0] DIV7_RECIP     = 32'd74899;
  localparam int          DIV7_SHIFT     = 19;

  localparam logic [3:0]  MONTH_FEB      = 4'd2;
  localparam logic [3:0]  MONTH_DEC      = 4'd12;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } utg_in_t;

  // after date decode
  typedef struct packed {
    logic        ok;
    logic [6:0]  yo;       // year - 2000
    logic [8:0]  doy;      // day of year, from 0
    logic        carry;    // second of day plus leap offset wrapped a day
    logic [16:0] sec_day;  // second of day plus leap offset, wrapped
    logic        nd;       // UTC+3 rolls into next day
    logic [16:0] sod3;     // UTC+3 second of day
    logic [6:0]  y3off;    // UTC+3 year - 2000
    logic [4:0]  four;     // GLONASS four-year period
  } utg_s1_t;

  // day counts, ready for the week split
  typedef struct packed {
    logic        ok;
    logic [15:0] dgps;
    logic [15:0] dgal;
    logic [16:0] sec_day;
    logic [4:0]  four;
    logic [10:0] gday;
    logic [16:0] sod3;
  } utg_s2_t;

  typedef struct packed {
    logic        date_ok;
    logic [12:0] gps_week;
    logic [19:0] gps_sec_of_week;
    logic [12:0] gal_week;
    logic [19:0] gal_sec_of_week;
    logic [4:0]  glo_four_year;
    logic [10:0] glo_day;
    logic [16:0] glo_sec_of_day;
  } utg_out_t;

  function automatic logic [8:0] cum_days(input logic [3:0] m);
    case (m)
      4'd1:    cum_days = 9'd0;
      4'd2:    cum_days = 9'd31;
      4'd3:    cum_days = 9'd59;
      4'd4:    cum_days = 9'd90;
      4'd5:    cum_days = 9'd120;
      4'd6:    cum_days = 9'd151;
      4'd7:    cum_days = 9'd181;
      4'd8:    cum_days = 9'd212;
      4'd9:    cum_days = 9'd243;
      4'd10:   cum_days = 9'd273;
      4'd11:   cum_days = 9'd304;
      4'd12:   cum_days = 9'd334;
      default: cum_days = 9'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd2:                   month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default:                month_len = 5'd31;
    endcase
  endfunction

  // leap second offset by year - 2000
  function automatic logic [4:0] leap_offset(input logic [6:0] yo);
    if (yo >= 7'd17) leap_offset = 5'd18;
    else if (yo >= 7'd16) leap_offset = 5'd17;
    else if (yo >= 7'd13) leap_offset = 5'd16;
    else if (yo >= 7'd9) leap_offset = 5'd15;
    else if (yo >= 7'd6) leap_offset = 5'd14;
    else leap_offset = 5'd13;
  endfunction

endpackage
`default_nettype wire

// ===== src/utg_date_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utg_date_stage
// Two pipeline stages: check and decode the date, then form day counts.
// ----------------------------------------------------------------------------
module utg_date_stage import utg_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire utg_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output utg_s2_t      out_data
);

  logic    va_r, va_nxt, vb_r, vb_nxt;
  logic    rdy_a, rdy_b;
  utg_s1_t a_r, a_nxt;
  utg_s2_t b_r, b_nxt;

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;
  assign va_nxt   = rdy_a ? in_valid : va_r;
  assign vb_nxt   = rdy_b ? va_r : vb_r;

  // stage 1: validity, day of year, seconds of day
  always_comb begin
    logic [11:0] yo12;
    logic [6:0]  yo;
    logic        leap;
    logic [16:0] sod;
    logic [16:0] s;
    logic [16:0] s3;
    logic        dec31;
    logic [6:0]  y3;
    yo12  = in_data.year - BASE_YEAR;
    yo    = yo12[6:0];
    leap  = (yo[1:0] == 2'd0);
    sod   = 17'(in_data.hour) * 17'd3600 + 17'(in_data.minute) * 17'd60
            + 17'(in_data.second);
    s     = sod + 17'(leap_offset(yo));
    s3    = sod + UTC3_SHIFT;
    dec31 = (in_data.month == MONTH_DEC) && (in_data.day == 5'd31);
    a_nxt.ok = (in_data.year >= BASE_YEAR) && (in_data.year <= LAST_YEAR) &&
               (in_data.month >= 4'd1) && (in_data.month <= MONTH_DEC) &&
               (in_data.hour <= 5'd23) && (in_data.minute <= 6'd59) &&
               (in_data.second <= 6'd59) && (in_data.day >= 5'd1) &&
               (in_data.day <= month_len(in_data.month, leap));
    a_nxt.yo      = yo;
    a_nxt.doy     = cum_days(in_data.month)
                    + 9'((leap && (in_data.month > MONTH_FEB)) ? 1 : 0)
                    + 9'(in_data.day) - 9'd1;
    a_nxt.carry   = (s >= SEC_PER_DAY);
    a_nxt.sec_day = (s >= SEC_PER_DAY) ? s - SEC_PER_DAY : s;
    a_nxt.nd      = (s3 >= SEC_PER_DAY);
    a_nxt.sod3    = (s3 >= SEC_PER_DAY) ? s3 - SEC_PER_DAY : s3;
    y3            = yo + 7'((a_nxt.nd && dec31) ? 1 : 0);
    a_nxt.y3off   = y3;
    a_nxt.four    = 5'((8'(y3) + 8'd7) >> 2);
  end

  // stage 2: day counts from each epoch, GLONASS day in period
  always_comb begin
    logic [15:0] days;
    logic [15:0] days3;
    logic [6:0]  bo;
    logic [15:0] dbase;
    logic [15:0] gd;
    days  = 16'(a_r.yo) * 16'd365 + 16'((8'(a_r.yo) + 8'd3) >> 2) + 16'(a_r.doy);
    days3 = days + 16'(a_r.nd);
    bo    = {a_r.y3off[6:2], 2'b00};
    dbase = 16'(bo) * 16'd365 + 16'(bo[6:2]);
    gd    = days3 - dbase + 16'(a_r.sod3 != 17'd0);
    b_nxt.ok      = a_r.ok;
    b_nxt.dgps    = days + GPS_EPOCH_DAYS + 16'(a_r.carry);
    b_nxt.dgal    = days + GAL_EPOCH_DAYS + 16'(a_r.carry);
    b_nxt.sec_day = a_r.sec_day;
    b_nxt.four    = a_r.four;
    b_nxt.gday    = gd[10:0];
    b_nxt.sod3    = a_r.sod3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_r <= a_nxt;
    end
    if (rdy_b) begin
      b_r <= b_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_data  = b_r;

endmodule
`default_nettype wire

// ===== src/utg_week_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utg_week_stage
// Two pipeline stages: split day counts into weeks and seconds of week.
// ----------------------------------------------------------------------------
module utg_week_stage import utg_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire utg_s2_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output utg_out_t     out_data
);

  logic        vc_r, vc_nxt, vd_r, vd_nxt;
  logic        rdy_c, rdy_d;
  utg_s2_t     c_r;
  logic [12:0] qg_r, qg_nxt, qa_r, qa_nxt;
  utg_out_t    d_r, d_nxt;
  logic [31:0] pg, pa;

  assign rdy_d    = !vd_r || out_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign in_ready = rdy_c;
  assign vc_nxt   = rdy_c ? in_valid : vc_r;
  assign vd_nxt   = rdy_d ? vc_r : vd_r;

  // stage 3: divide day counts by seven with a reciprocal multiply
  assign pg     = 32'(in_data.dgps) * DIV7_RECIP;
  assign pa     = 32'(in_data.dgal) * DIV7_RECIP;
  assign qg_nxt = pg[DIV7_SHIFT+12:DIV7_SHIFT];
  assign qa_nxt = pa[DIV7_SHIFT+12:DIV7_SHIFT];

  // stage 4: day of week to seconds, zero everything on a bad date
  always_comb begin
    logic [15:0] rg;
    logic [15:0] ra;
    rg = c_r.dgps - 16'(qg_r) * 16'd7;
    ra = c_r.dgal - 16'(qa_r) * 16'd7;
    d_nxt = '0;
    if (c_r.ok) begin
      d_nxt.date_ok         = 1'b1;
      d_nxt.gps_week        = qg_r;
      d_nxt.gps_sec_of_week = 20'(rg[2:0]) * 20'(SEC_PER_DAY) + 20'(c_r.sec_day);
      d_nxt.gal_week        = qa_r;
      d_nxt.gal_sec_of_week = 20'(ra[2:0]) * 20'(SEC_PER_DAY) + 20'(c_r.sec_day);
      d_nxt.glo_four_year   = c_r.four;
      d_nxt.glo_day         = c_r.gday;
      d_nxt.glo_sec_of_day  = c_r.sod3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      vc_r <= vc_nxt;
      vd_r <= vd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_r  <= in_data;
      qg_r <= qg_nxt;
      qa_r <= qa_nxt;
    end
    if (rdy_d) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = vd_r;
  assign out_data  = d_r;

endmodule
`default_nettype wire

// ===== src/utc_to_gnss_time_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utc_to_gnss_time_unit
// Convert a UTC calendar timestamp (2000..2099) to GPS, Galileo and GLONASS
// time forms.
// ----------------------------------------------------------------------------
// Usage:
//   Present one UTC timestamp per transaction on the in_ stream; each one
//   yields exactly one result transaction on the out_ stream, in order.
//   The transaction is registered in each stage in turn, and out_tvalid
//   rises once it reaches the last one. While out_tready stays high, a new
//   transaction is taken every cycle, so sustained throughput is one
//   timestamp per cycle; the four register stages (date decode, day count,
//   divide by seven, week split) each hold one transaction.
//   An invalid date or time yields date_ok low with every other field zero.
//   Reset (rst_n low, synchronous) drops all transactions in flight; the
//   block then accepts at once.
//   When the receiver stalls, each stage holds its transaction and fills in
//   behind it; in_tready falls only when all four stages are full. Nothing
//   is dropped or repeated.
//   GLONASS fields use the UTC+3 timestamp, which may roll into the next
//   day or year.
// ----------------------------------------------------------------------------
module utc_to_gnss_time_unit import utg_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
  // second[37:32], zero fill[39:38]
  input  wire logic [39:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // date_ok[0], gps_week[13:1], gps_sec_of_week[33:14], gal_week[46:34],
  // gal_sec_of_week[66:47], glo_four_year[71:67], glo_day[82:72],
  // glo_sec_of_day[99:83], zero fill[103:100]
  output logic [103:0]      out_tdata
);

  utg_in_t  in_item;
  utg_s2_t  mid_data;
  logic     mid_valid, mid_ready;
  utg_out_t res;

  // unpack the input transaction
  assign in_item.year   = in_tdata[11:0];
  assign in_item.month  = in_tdata[15:12];
  assign in_item.day    = in_tdata[20:16];
  assign in_item.hour   = in_tdata[25:21];
  assign in_item.minute = in_tdata[31:26];
  assign in_item.second = in_tdata[37:32];

  // stages 1-2: validate, decode to day counts
  utg_date_stage u_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_item),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  // stages 3-4: split into weeks, seconds of week; last stage is the output register
  utg_week_stage u_week (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  // pack the result transaction
  assign out_tdata = {4'd0, res.glo_sec_of_day, res.glo_day, res.glo_four_year,
                      res.gal_sec_of_week, res.gal_week, res.gps_sec_of_week,
                      res.gps_week, res.date_ok};

endmodule
`default_nettype wire

// ===== verif/utg_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utg_tb_pkg
// Calendar arithmetic, expected-time predictor and result board for the
// UTC to GNSS time unit bench.
// ----------------------------------------------------------------------------
package utg_tb_pkg;
  import utg_pkg::*;

  localparam longint unsigned DAY_SECS  = 86400;
  localparam longint unsigned WEEK_SECS = 604800;
  localparam longint unsigned MSK_SHIFT = 10800;  // UTC+3
  // 1980-01-06 to 2000-01-01: 7305 days counted from 1980-01-01, less five
  localparam longint unsigned GPS_START_DAYS = 7300;
  // 1999-08-22 to 2000-01-01: 10 + 30 + 31 + 30 + 31
  localparam longint unsigned GAL_START_DAYS = 132;
  localparam int MAX_PRINTED = 100;

  function automatic bit is_leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    case (m)
      2: begin
        return is_leap_year(y) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // days from 2000-01-01 to y-m-d, valid for y in 2000..2100
  function automatic longint unsigned days_from_2000(int unsigned y, int unsigned m,
                                                     int unsigned d);
    int unsigned     yo;
    longint unsigned n;
    yo = y - 2000;
    n = 365 * yo + (yo + 3) / 4 - (yo + 99) / 100 + (yo + 399) / 400;
    for (int unsigned k = 1; k < m; k++) n += month_days(y, k);
    return n + d - 1;
  endfunction

  function automatic longint unsigned leap_secs(int unsigned y);
    return 13 + (y >= 2006) + (y >= 2009) + (y >= 2013) + (y >= 2016) + (y >= 2017);
  endfunction

  class gnss_time_board;
    utg_out_t pending_times[$];
    int       errors;
    int       checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    function utg_out_t convert_stamp(utg_in_t st);
      utg_out_t        r;
      bit              valid;
      longint unsigned sod, t_utc, gps, gal, t3, delta;
      int unsigned     y3;
      r = '0;
      valid = st.year >= 2000 && st.year <= 2099 && st.month >= 1 && st.month <= 12 &&
              st.day >= 1 && st.hour <= 23 && st.minute <= 59 && st.second <= 59;
      if (valid) valid = st.day <= month_days(st.year, st.month);
      if (!valid) return r;

      sod   = longint'(st.hour) * 3600 + longint'(st.minute) * 60 + longint'(st.second);
      t_utc = days_from_2000(st.year, st.month, st.day) * DAY_SECS + sod;
      gps   = t_utc + GPS_START_DAYS * DAY_SECS + leap_secs(st.year);
      gal   = t_utc + GAL_START_DAYS * DAY_SECS + leap_secs(st.year);

      // GLONASS runs on UTC+3; the last evening of a year rolls into the next
      y3 = st.year;
      if (sod + MSK_SHIFT >= DAY_SECS && st.month == 12 && st.day == 31) y3++;
      t3    = t_utc + MSK_SHIFT;
      delta = t3 - days_from_2000(y3 - y3 % 4, 1, 1) * DAY_SECS;

      r.date_ok         = 1'b1;
      r.gps_week        = 13'(gps / WEEK_SECS);
      r.gps_sec_of_week = 20'(gps % WEEK_SECS);
      r.gal_week        = 13'(gal / WEEK_SECS);
      r.gal_sec_of_week = 20'(gal % WEEK_SECS);
      r.glo_four_year   = 5'((y3 - 1996 + 3) / 4);
      r.glo_day         = 11'((delta + DAY_SECS - 1) / DAY_SECS);
      r.glo_sec_of_day  = 17'(t3 % DAY_SECS);
      return r;
    endfunction

    function void note_stamp(utg_in_t st);
      pending_times.push_back(convert_stamp(st));
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("tb: mismatch: %s", msg);
    endtask

    task compare_field(string name, longint unsigned got, longint unsigned want);
      if (got != want) begin
        report_mismatch($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
      end
    endtask

    task check_result(logic [103:0] raw);
      utg_out_t got, want;
      got.date_ok         = raw[0];
      got.gps_week        = raw[13:1];
      got.gps_sec_of_week = raw[33:14];
      got.gal_week        = raw[46:34];
      got.gal_sec_of_week = raw[66:47];
      got.glo_four_year   = raw[71:67];
      got.glo_day         = raw[82:72];
      got.glo_sec_of_day  = raw[99:83];
      if (pending_times.size() == 0) begin
        report_mismatch($sformatf("result %0h with nothing pending", raw));
        return;
      end
      want = pending_times.pop_front();
      compare_field("date_ok", got.date_ok, want.date_ok);
      compare_field("gps_week", got.gps_week, want.gps_week);
      compare_field("gps_sec_of_week", got.gps_sec_of_week, want.gps_sec_of_week);
      compare_field("gal_week", got.gal_week, want.gal_week);
      compare_field("gal_sec_of_week", got.gal_sec_of_week, want.gal_sec_of_week);
      compare_field("glo_four_year", got.glo_four_year, want.glo_four_year);
      compare_field("glo_day", got.glo_day, want.glo_day);
      compare_field("glo_sec_of_day", got.glo_sec_of_day, want.glo_sec_of_day);
      checked++;
    endtask
  endclass

endpackage

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream bench for utc_to_gnss_time_unit: directed calendar corner cases
// and random timestamps go in through bursts and gaps, results come out
// under a shifting stall pattern with one long hold-off, and every result
// is checked field by field against a predicted GPS, Galileo and GLONASS
// time.
// ----------------------------------------------------------------------------
module tb;
  import utg_pkg::*;
  import utg_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;    // four-stage pipe, plus margin
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned HOLD_AFTER   = 300;   // results seen before the hold-off
  localparam int unsigned RANDOM_ITEMS = 1000;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
  // second[37:32], zero fill[39:38]
  logic [39:0]  in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // date_ok[0], gps_week[13:1], gps_sec_of_week[33:14], gal_week[46:34],
  // gal_sec_of_week[66:47], glo_four_year[71:67], glo_day[82:72],
  // glo_sec_of_day[99:83], zero fill[103:100]
  logic [103:0] out_tdata;

  gnss_time_board board;
  utg_in_t        stamp_q[$];
  utg_in_t        rand_st;
  int unsigned    pick;
  int unsigned    len;
  bit             rx_holding  = 1'b0;
  int unsigned    cycle_count = 0;

  utc_to_gnss_time_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic utg_in_t make_stamp(int unsigned y, int unsigned mo, int unsigned d,
                                         int unsigned h, int unsigned mi, int unsigned s);
    utg_in_t st;
    st.year   = 12'(y);
    st.month  = 4'(mo);
    st.day    = 5'(d);
    st.hour   = 5'(h);
    st.minute = 6'(mi);
    st.second = 6'(s);
    return st;
  endfunction

  // Offer the queued timestamps in bursts with random gaps. Each accepted
  // transaction is handed to the board at the edge that takes it.
  task automatic drive_stamps();
    int unsigned sent, burst_left, gap_left;
    utg_in_t     st;
    sent       = 0;
    burst_left = 0;
    gap_left   = 0;
    while (sent < stamp_q.size()) begin
      @(posedge clk);
      if (in_tvalid && in_tready) begin
        board.note_stamp(stamp_q[sent]);
        sent++;
      end
      // hold an offer that is still waiting for in_tready
      if (!in_tvalid || in_tready) begin
        if (sent == stamp_q.size()) begin
          in_tvalid <= 1'b0;
        end else if (gap_left != 0 && !rx_holding) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          st = stamp_q[sent];
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b00, st.second, st.minute, st.hour, st.day, st.month, st.year};
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            // mostly short bursts, now and then a long unbroken run
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 9);
          end
        end
      end
    end
  endtask

  // Take results under a stall pattern that switches at random among four modes,
  // and once drop out_tready for a long stretch so the pipe fills and
  // in_tready falls while the sender keeps offering.
  task automatic watch_results();
    int unsigned mode, mode_left, hold_left;
    bit          ready, hold_done;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) board.check_result(out_tdata);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        rx_holding = (hold_left != 0);
        ready      = 1'b0;
      end else if (!hold_done && board.checked >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        hold_left  = LONG_HOLD;
        rx_holding = 1'b1;
        ready      = 1'b0;
      end else begin
        case (mode)
          0: begin
            ready = 1'b1;
          end
          1: begin
            ready = ($urandom_range(0, 1) != 0);
          end
          2: begin
            ready = ($urandom_range(0, 3) == 0);
          end
          default: begin
            ready = !out_tready;
          end
        endcase
      end
      out_tready <= ready;
    end
  endtask

  // Stop a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    board = new();

    // first and last timestamps of the range
    stamp_q.push_back(make_stamp(2000, 1, 1, 0, 0, 0));
    stamp_q.push_back(make_stamp(2099, 12, 31, 23, 59, 59));
    // UTC+3 midnight on Jan 1 of a leap year, and the second before it
    stamp_q.push_back(make_stamp(2003, 12, 31, 20, 59, 59));
    stamp_q.push_back(make_stamp(2003, 12, 31, 21, 0, 0));
    // UTC+3 rolls into 2100, the highest four-year period
    stamp_q.push_back(make_stamp(2099, 12, 31, 21, 0, 0));
    // leap days: century leap year, ordinary leap year, non-leap edge
    stamp_q.push_back(make_stamp(2000, 2, 29, 12, 34, 56));
    stamp_q.push_back(make_stamp(2004, 2, 29, 23, 0, 1));
    stamp_q.push_back(make_stamp(2001, 2, 28, 6, 30, 0));
    // leap offset steps
    stamp_q.push_back(make_stamp(2005, 12, 31, 23, 59, 59));
    stamp_q.push_back(make_stamp(2006, 1, 1, 0, 0, 0));
    stamp_q.push_back(make_stamp(2009, 1, 1, 0, 0, 0));
    stamp_q.push_back(make_stamp(2013, 1, 1, 0, 0, 0));
    stamp_q.push_back(make_stamp(2016, 7, 1, 0, 0, 0));
    stamp_q.push_back(make_stamp(2017, 1, 1, 0, 0, 0));
    // invalid stamps: year, month, day, hour or minute out of range, and every field at its maximum
    stamp_q.push_back(make_stamp(1999, 12, 31, 23, 59, 59));
    stamp_q.push_back(make_stamp(2100, 1, 1, 0, 0, 0));
    stamp_q.push_back(make_stamp(4095, 15, 31, 31, 63, 63));
    stamp_q.push_back(make_stamp(2010, 0, 10, 1, 2, 3));
    stamp_q.push_back(make_stamp(2010, 13, 10, 1, 2, 3));
    stamp_q.push_back(make_stamp(2010, 5, 0, 1, 2, 3));
    stamp_q.push_back(make_stamp(2001, 2, 29, 0, 0, 0));
    stamp_q.push_back(make_stamp(2010, 4, 31, 0, 0, 0));
    stamp_q.push_back(make_stamp(2010, 5, 5, 24, 0, 0));
    stamp_q.push_back(make_stamp(2010, 5, 5, 0, 60, 0));
    // leap second field
    stamp_q.push_back(make_stamp(2016, 12, 31, 23, 59, 60));

    // random part: mostly good stamps, some year-end evenings, some broken
    repeat (RANDOM_ITEMS) begin
      pick           = $urandom_range(0, 99);
      rand_st.year   = 12'($urandom_range(2000, 2099));
      rand_st.month  = 4'($urandom_range(1, 12));
      len            = month_days(rand_st.year, rand_st.month);
      rand_st.day    = 5'($urandom_range(1, len));
      rand_st.hour   = 5'($urandom_range(0, 23));
      rand_st.minute = 6'($urandom_range(0, 59));
      rand_st.second = 6'($urandom_range(0, 59));
      if (pick < 10) begin
        // last evening of a year, where UTC+3 may roll into the next year
        rand_st.month = 4'd12;
        rand_st.day   = 5'd31;
        rand_st.hour  = 5'($urandom_range(20, 23));
      end else if (pick < 16) begin
        // raw noise over the full width of every field
        rand_st.year   = 12'($urandom);
        rand_st.month  = 4'($urandom);
        rand_st.day    = 5'($urandom);
        rand_st.hour   = 5'($urandom);
        rand_st.minute = 6'($urandom);
        rand_st.second = 6'($urandom);
      end else if (pick < 24) begin
        // break one field of an otherwise good stamp
        case ($urandom_range(0, 5))
          0: begin
            rand_st.year = ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 1999))
                                                       : 12'($urandom_range(2100, 4095));
          end
          1: begin
            rand_st.month = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(13, 15));
          end
          2: begin
            if (len == 31 || $urandom_range(0, 1) == 0) rand_st.day = 5'd0;
            else rand_st.day = 5'($urandom_range(len + 1, 31));
          end
          3: begin
            rand_st.hour = 5'($urandom_range(24, 31));
          end
          4: begin
            rand_st.minute = 6'($urandom_range(60, 63));
          end
          default: begin
            rand_st.second = 6'($urandom_range(60, 63));
          end
        endcase
      end
      stamp_q.push_back(rand_st);
    end

    // hold reset, then release it at a clock edge
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    fork
      watch_results();
    join_none
    drive_stamps();

    // drain: every accepted transaction must come back
    while (board.pending_times.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
